// ----- rtl/smm_pkg.sv -----
package smm_pkg;

  localparam int MAX_SIZE_DEF = 8;
  localparam int SIZE_W       = 4;
  localparam int IDX_W        = 3;
  localparam int DATA_W       = 32;
  localparam int PROD_W       = 2 * SIZE_W;
  localparam int JOB_DEPTH    = 2;
  localparam int RES_DEPTH    = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

  // One bank of a store holds max_size * max_size words.
  function automatic int addr_w(input int max_size);
    return (max_size > 1) ? $clog2(max_size * max_size) : 1;
  endfunction

  typedef struct packed {
    logic              bank;
    logic [SIZE_W-1:0] size;
  } job_t;

  typedef struct packed {
    logic              valid;
    logic              bank;
  } bank_free_t;

  typedef struct packed {
    logic [DATA_W-1:0] product;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
  } result_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

// ----- rtl/smm_fifo.sv -----
module smm_fifo
  import smm_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   slots [DEPTH];
  logic [PW-1:0]  wp;
  logic [PW-1:0]  rp;
  logic [CNW-1:0] count;
  logic           push_ok;
  logic           pop_ok;

  assign full    = (count == CNW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push & ~full;
  assign pop_ok  = pop & ~empty;
  assign rd_data = slots[rp];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (pop_ok) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      unique case ({push_ok, pop_ok})
        2'b10:   count <= count + CNW'(1);
        2'b01:   count <= count - CNW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/smm_front.sv -----
module smm_front
  import smm_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [DATA_W-1:0]        a_element,
  input  logic [DATA_W-1:0]        b_element,
  input  logic [SIZE_W-1:0]        size,
  input  logic                     job_full,
  output logic                     job_push,
  output job_t                     job,
  input  bank_free_t               bank_free,
  output logic                     wr_en,
  output logic [addr_w(MAX_SIZE):0] wr_addr,
  output logic [DATA_W-1:0]        wr_a,
  output logic [DATA_W-1:0]        wr_b
);

  localparam int AW = addr_w(MAX_SIZE);
  localparam int CW = $clog2(MAX_SIZE * MAX_SIZE + 1);

  logic [CW-1:0]     load_count;
  logic [CW-1:0]     load_count_next;
  logic              wr_bank;
  logic [1:0]        bank_busy;
  logic [1:0]        bank_busy_next;
  logic              accept;
  logic              done;
  logic [PROD_W-1:0] total;
  logic [PROD_W-1:0] count_inc;

  assign total     = PROD_W'(size) * PROD_W'(size);
  assign count_inc = PROD_W'(load_count) + PROD_W'(1);
  assign done      = (count_inc >= total);

  // Hold off items if the job queue is full or the bank to fill is in use.
  assign full   = bank_busy[wr_bank] | job_full;
  assign accept = push & ~full;

  assign wr_en   = accept;
  assign wr_addr = {wr_bank, load_count[AW-1:0]};
  assign wr_a    = a_element;
  assign wr_b    = b_element;

  assign job_push = accept & done;
  assign job      = '{bank: wr_bank, size: size};

  assign load_count_next = done ? '0 : count_inc[CW-1:0];

  always_comb begin
    bank_busy_next = bank_busy;
    if (bank_free.valid) begin
      bank_busy_next[bank_free.bank] = 1'b0;
    end
    if (job_push) begin
      bank_busy_next[wr_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      wr_bank    <= 1'b0;
      bank_busy  <= '0;
    end else begin
      if (accept) begin
        load_count <= load_count_next;
      end
      if (job_push) begin
        wr_bank <= ~wr_bank;
      end
      bank_busy <= bank_busy_next;
    end
  end

endmodule

// ----- rtl/smm_back.sv -----
module smm_back
  import smm_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_empty,
  output logic                      job_pop,
  input  job_t                      job,
  input  logic                      wr_en,
  input  logic [addr_w(MAX_SIZE):0] wr_addr,
  input  logic [DATA_W-1:0]         wr_a,
  input  logic [DATA_W-1:0]         wr_b,
  input  logic                      out_taken,
  output logic                      res_push,
  output result_t                   res,
  output bank_free_t                bank_free
);

  localparam int AW    = addr_w(MAX_SIZE);
  localparam int MEM_D = 2 ** (AW + 1);
  localparam int CRW   = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic             first;
    logic             last;
    logic             last_run;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  logic [DATA_W-1:0] mem_a [MEM_D];
  logic [DATA_W-1:0] mem_b [MEM_D];

  back_state_t       state;
  back_state_t       state_next;
  logic              bank;
  logic [SIZE_W-1:0] n;
  logic [IDX_W-1:0]  i;
  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  k;
  logic [CRW-1:0]    credit;
  logic              issue;
  logic              start;
  logic              k_end;
  logic              j_end;
  logic              i_end;
  logic [PROD_W-1:0] a_off;
  logic [PROD_W-1:0] b_off;
  logic [AW:0]       rd_addr_a;
  logic [AW:0]       rd_addr_b;

  logic              s1_v;
  tag_t              s1_tag;
  logic [DATA_W-1:0] a_q;
  logic [DATA_W-1:0] b_q;
  logic              s2_v;
  tag_t              s2_tag;
  logic [DATA_W-1:0] s2_prod;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] acc_sum;

  assign k_end = (SIZE_W'(k) == n - SIZE_W'(1));
  assign j_end = (SIZE_W'(j) == n - SIZE_W'(1));
  assign i_end = (SIZE_W'(i) == n - SIZE_W'(1));
  assign start = issue & (k == '0);

  // Element (r,c) of a matrix sits at word r*n+c of its bank.
  assign a_off     = PROD_W'(i) * PROD_W'(n) + PROD_W'(k);
  assign b_off     = PROD_W'(k) * PROD_W'(n) + PROD_W'(j);
  assign rd_addr_a = {bank, a_off[AW-1:0]};
  assign rd_addr_b = {bank, b_off[AW-1:0]};

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!job_empty) begin
        state_next = BK_RUN;
      end
      BK_RUN: if (issue && k_end && j_end && i_end) begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Start an element only with a free slot reserved in the result queue.
  always_comb begin
    job_pop = 1'b0;
    issue   = 1'b0;
    unique case (state)
      BK_IDLE: job_pop = ~job_empty;
      BK_RUN:  issue   = (k != '0) || (credit < CRW'(RES_DEPTH));
    endcase
    bank_free.valid = issue & k_end & j_end & i_end;
    bank_free.bank  = bank;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_a;
      mem_b[wr_addr] <= wr_b;
    end
    if (issue) begin
      a_q <= mem_a[rd_addr_a];
      b_q <= mem_b[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      bank <= job.bank;
      n    <= job.size;
      i    <= '0;
      j    <= '0;
      k    <= '0;
    end else if (issue) begin
      if (k_end) begin
        k <= '0;
        if (j_end) begin
          j <= '0;
          i <= i + IDX_W'(1);
        end else begin
          j <= j + IDX_W'(1);
        end
      end else begin
        k <= k + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= BK_IDLE;
      credit <= '0;
      s1_v   <= 1'b0;
      s2_v   <= 1'b0;
    end else begin
      state <= state_next;
      unique case ({start, out_taken})
        2'b10:   credit <= credit + CRW'(1);
        2'b01:   credit <= credit - CRW'(1);
        default: credit <= credit;
      endcase
      s1_v <= issue;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag  <= '{first: (k == '0), last: k_end, last_run: i_end & j_end,
                 row: i, col: j};
    s2_tag  <= s1_tag;
    s2_prod <= a_q * b_q;
    if (s2_v) begin
      acc <= acc_sum;
    end
  end

  assign acc_sum  = (s2_tag.first ? '0 : acc) + s2_prod;
  assign res_push = s2_v & s2_tag.last;
  assign res      = '{product: acc_sum, row: s2_tag.row, col: s2_tag.col,
                      last: s2_tag.last_run};

endmodule

// ----- rtl/square_matrix_multiply.sv -----
// Square matrix multiplier, C = A x B, for n by n signed 32-bit matrices with
// results wrapped modulo 2^32. Push one element of A and the element of B at
// the same place per item, row-major; after n*n items the n*n elements of C
// come out of the result queue in row-major order with their row, column and
// a last marker on C[n-1][n-1]. n comes from the size register (0 acts as 1,
// values above MAX_SIZE act as MAX_SIZE); write it only while the block is
// idle. Items go in at one per cycle while full is low into one of two store
// banks, so the next pair of matrices loads while the back end multiplies the
// previous one. The back end takes a job from the queue in its idle state and
// then does one multiply-accumulate per cycle, reading one word of each store,
// as long as it has a result queue slot reserved for each element it starts.
// The read words are registered, then their product, and the accumulated sum
// of an element's last term goes into the result queue; unpopped results
// make the back end wait for a slot. No clearing pass runs after reset.
module square_matrix_multiply
  import smm_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [SIZE_W-1:0]        cfg_data,
  input  logic                     push,
  output logic                     full,
  input  logic signed [DATA_W-1:0] a_element,
  input  logic signed [DATA_W-1:0] b_element,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [DATA_W-1:0] product_element,
  output logic [IDX_W-1:0]         row_index,
  output logic [IDX_W-1:0]         column_index,
  output logic                     last_of_run
);

  localparam int AW = addr_w(MAX_SIZE);

  logic [SIZE_W-1:0] matrix_size;
  logic [SIZE_W-1:0] size_eff;

  logic              job_push;
  logic              job_pop;
  logic              job_full;
  logic              job_empty;
  job_t              job_in;
  job_t              job_out;

  logic              wr_en;
  logic [AW:0]       wr_addr;
  logic [DATA_W-1:0] wr_a;
  logic [DATA_W-1:0] wr_b;
  bank_free_t        bank_free;

  logic              res_push;
  logic              res_full;
  logic              out_taken;
  result_t           res_in;
  result_t           res_out;

  // Size register: always ready, clamp to the legal range on use.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      matrix_size <= cfg_data;
    end
  end

  always_comb begin
    priority if (matrix_size == '0) begin
      size_eff = SIZE_W'(1);
    end else if (matrix_size > SIZE_W'(MAX_SIZE)) begin
      size_eff = SIZE_W'(MAX_SIZE);
    end else begin
      size_eff = matrix_size;
    end
  end

  // Front end: store incoming items, hand a finished pair of matrices over.
  smm_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .a_element (a_element),
    .b_element (b_element),
    .size      (size_eff),
    .job_full  (job_full),
    .job_push  (job_push),
    .job       (job_in),
    .bank_free (bank_free),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_a      (wr_a),
    .wr_b      (wr_b)
  );

  // Job queue between front and back end.
  smm_fifo #(
    .W     ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .wr_data (job_in),
    .full    (job_full),
    .pop     (job_pop),
    .rd_data (job_out),
    .empty   (job_empty)
  );

  // Back end: stores, read sequencer and multiply-accumulate pipeline.
  smm_back #(
    .MAX_SIZE (MAX_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job       (job_out),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_a      (wr_a),
    .wr_b      (wr_b),
    .out_taken (out_taken),
    .res_push  (res_push),
    .res       (res_in),
    .bank_free (bank_free)
  );

  // Result queue: the back end reserves a slot before it starts an element.
  assign out_taken = pop & ~empty;

  smm_fifo #(
    .W     ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign product_element = res_out.product;
  assign row_index       = res_out.row;
  assign column_index    = res_out.col;
  assign last_of_run     = res_out.last;

  // Credit scheme must never overrun the result queue.
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // Bank tracking must never overrun the job queue.
  a_job_no_overflow: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !job_full)
    else $error("job pushed into full queue");

  // The last element of a product is on the diagonal.
  a_last_diag: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_of_run) |-> (row_index == column_index))
    else $error("last marker off the diagonal");

  // A bank is released only while the back end is running.
  a_free_running: assert property (@(posedge clk) disable iff (rst)
    bank_free.valid |-> !job_pop)
    else $error("bank released while starting a job");

endmodule
